// File: src/jpid_pkg.sv
// Package for the joint PID controller: field widths, limits, opcodes and
// the stage record passed from the state memories to the arithmetic pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jpid_pkg;

  localparam int NUM_JOINTS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  localparam int JOINT_W     = 4;
  localparam int VAL_W       = 24;
  localparam int ERR_W       = 25;
  localparam int FF_W        = 32;
  localparam int GAIN_W      = 24;
  localparam int INTEG_W     = 40;
  localparam int INTEG_SPLIT = 20;
  localparam int SUM_W       = 64;
  localparam int DRIVE_W     = 32;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 40'sh80_0000_0000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } jpid_op_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] kd;
    logic signed [GAIN_W-1:0] ki;
  } jpid_gains_t;

  typedef struct packed {
    logic [JOINT_W-1:0]        joint;
    logic signed [ERR_W-1:0]   perr;
    logic signed [VAL_W-1:0]   vel;
    logic signed [FF_W-1:0]    ff;
    jpid_gains_t               gains;
    logic signed [INTEG_W-1:0] integ;
    logic                      isat;
  } jpid_stage_t;

endpackage

`default_nettype wire

// File: src/jpid_if.sv
// Channel interfaces of the joint PID controller: request and response.
// Depends on jpid_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface jpid_req_if import jpid_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [0:0]                opcode;
  logic [JOINT_W-1:0]        joint;
  logic signed [VAL_W-1:0]   position;
  logic signed [VAL_W-1:0]   velocity;
  logic signed [VAL_W-1:0]   pos_target;
  logic signed [FF_W-1:0]    feedforward;
  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_d;
  logic signed [GAIN_W-1:0]  gain_i;

  modport source (
    output valid, opcode, joint, position, velocity, pos_target, feedforward,
           gain_p, gain_d, gain_i,
    input  ready
  );
  modport sink (
    input  valid, opcode, joint, position, velocity, pos_target, feedforward,
           gain_p, gain_d, gain_i,
    output ready
  );
endinterface

interface jpid_rsp_if import jpid_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [JOINT_W-1:0]        joint_out;
  logic signed [DRIVE_W-1:0] drive;
  logic                      saturated;

  modport source (
    output valid, joint_out, drive, saturated,
    input  ready
  );
  modport sink (
    input  valid, joint_out, drive, saturated,
    output ready
  );
endinterface

`default_nettype wire

// File: src/joint_pid_controller.sv
// Joint PID controller top level: state memories followed by the arithmetic
// pipeline. Depends on jpid_pkg, jpid_req_if, jpid_rsp_if, jpid_mem, jpid_math.
//
// Use:
//   req carries one transaction per item. opcode OP_LOAD stores a joint's
//   three gains and clears its integrator; OP_SAMPLE carries position,
//   velocity, target and feedforward and yields one rsp transaction with the
//   joint index, the saturated drive value and the saturation flag. Loads and
//   items for joints at or above NUM_JOINTS yield nothing.
//   Throughput is one item per cycle, back to back, for any mix of joints,
//   while rsp is not stalled: the integrator and gains are read, updated and
//   written back in one stage, and the last write is forwarded to a following
//   read of the entry. From req acceptance to rsp valid an item passes the
//   registers for memory read, integrator update, products, partial sums,
//   final sum and shift, and drive. Reset clears the per-entry valid bits;
//   an entry not written since reset reads as zero, so no clearing pass is
//   needed. A stalled rsp holds its transaction; the pipeline keeps filling
//   its empty stages and req.ready falls only once every stage is occupied.
`timescale 1ns / 1ps
`default_nettype none

module joint_pid_controller import jpid_pkg::*; #(
  parameter int NUM_JOINTS = NUM_JOINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  jpid_req_if.sink   req,
  jpid_rsp_if.source rsp
);

  jpid_stage_t stage;
  logic        stage_valid;
  logic        stage_ready;

  jpid_mem #(.NUM_JOINTS(NUM_JOINTS)) u_mem (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .stage       (stage),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready)
  );

  jpid_math #(.FRAC_BITS(FRAC_BITS)) u_math (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .rsp         (rsp)
  );

  a_integ_clamp: assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage.isat |-> stage.integ == INTEG_MAX || stage.integ == INTEG_MIN)
    else $error("integrator flagged saturated but not at a limit");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid && !rsp.ready)
    else $error("request stalled while output side is free");

  a_joint_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> 32'(rsp.joint_out) < NUM_JOINTS)
    else $error("response for a joint that does not exist");

  a_sat_drive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.saturated |=> !rsp.valid || rsp.saturated ||
      $past(rsp.ready) || $stable(rsp.drive))
    else $error("held response changed");

endmodule

`default_nettype wire

// File: src/jpid_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module jpid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/jpid_mem.sv
// State stage: gain and integrator memories, entry valid bits, write-to-read
// forwarding and the saturating integrator update. Depends on jpid_pkg,
// jpid_req_if and jpid_ram.
`timescale 1ns / 1ps
`default_nettype none

module jpid_mem import jpid_pkg::*; #(
  parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  jpid_req_if.sink    req,
  output jpid_stage_t stage,
  output logic        stage_valid,
  input  wire logic   stage_ready
);

  localparam int IDX_W    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int GTAB_W   = $bits(jpid_gains_t);
  localparam int ISUM_W   = INTEG_W + 1;

  // stage 1 registers
  logic                      s1_valid;
  logic                      s1_present;
  logic [0:0]                s1_op;
  logic [IDX_W-1:0]          s1_idx;
  logic [JOINT_W-1:0]        s1_joint;
  logic signed [ERR_W-1:0]   s1_perr;
  logic signed [VAL_W-1:0]   s1_vel;
  logic signed [FF_W-1:0]    s1_ff;
  jpid_gains_t               s1_gains;

  logic                      en1;
  logic                      en2;
  logic [IDX_W-1:0]          raddr;

  logic [GTAB_W-1:0]         gain_rd;
  logic [INTEG_W-1:0]        integ_rd;
  logic [NUM_JOINTS-1:0]     gain_vld;
  logic [NUM_JOINTS-1:0]     integ_vld;

  logic                      gfwd_vld;
  logic [IDX_W-1:0]          gfwd_idx;
  jpid_gains_t               gfwd_data;
  logic                      ifwd_vld;
  logic [IDX_W-1:0]          ifwd_idx;
  logic signed [INTEG_W-1:0] ifwd_data;

  jpid_gains_t               gains_cur;
  logic signed [INTEG_W-1:0] integ_cur;
  logic signed [ISUM_W-1:0]  integ_sum;
  logic signed [INTEG_W-1:0] integ_new;
  logic                      integ_ovf;

  logic                      wr;
  logic                      gain_we;
  logic                      integ_we;
  logic signed [INTEG_W-1:0] integ_wdata;

  assign en2       = !stage_valid || stage_ready;
  assign en1       = !s1_valid || en2;
  assign req.ready = en1;

  // re-read the held entry while stalled so read data stays aligned
  assign raddr = en1 ? IDX_W'(req.joint) : s1_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= req.valid;
    end
    if (en1) begin
      s1_present <= (32'(req.joint) < NUM_JOINTS);
      s1_op      <= req.opcode;
      s1_idx     <= IDX_W'(req.joint);
      s1_joint   <= req.joint;
      s1_perr    <= ERR_W'(req.position) - ERR_W'(req.pos_target);
      s1_vel     <= req.velocity;
      s1_ff      <= req.feedforward;
      s1_gains   <= '{kp: req.gain_p, kd: req.gain_d, ki: req.gain_i};
    end
  end

  jpid_ram #(.WIDTH(GTAB_W), .DEPTH(NUM_JOINTS)) u_gain_ram (
    .clk   (clk),
    .we    (gain_we),
    .waddr (s1_idx),
    .wdata (s1_gains),
    .raddr (raddr),
    .rdata (gain_rd)
  );

  jpid_ram #(.WIDTH(INTEG_W), .DEPTH(NUM_JOINTS)) u_integ_ram (
    .clk   (clk),
    .we    (integ_we),
    .waddr (s1_idx),
    .wdata (integ_wdata),
    .raddr (raddr),
    .rdata (integ_rd)
  );

  always_comb begin
    if (gfwd_vld && gfwd_idx == s1_idx) begin
      gains_cur = gfwd_data;
    end else if (gain_vld[s1_idx]) begin
      gains_cur = jpid_gains_t'(gain_rd);
    end else begin
      gains_cur = '0;
    end

    if (ifwd_vld && ifwd_idx == s1_idx) begin
      integ_cur = ifwd_data;
    end else if (integ_vld[s1_idx]) begin
      integ_cur = $signed(integ_rd);
    end else begin
      integ_cur = '0;
    end

    integ_sum = ISUM_W'(integ_cur) + ISUM_W'(s1_perr);
    integ_ovf = integ_sum[ISUM_W-1] != integ_sum[ISUM_W-2];
    if (integ_ovf) begin
      integ_new = integ_sum[ISUM_W-1] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_new = integ_sum[INTEG_W-1:0];
    end
  end

  assign wr          = s1_valid && s1_present && en2;
  assign gain_we     = wr && (s1_op == OP_LOAD);
  assign integ_we    = wr;
  assign integ_wdata = (s1_op == OP_LOAD) ? '0 : integ_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_vld  <= '0;
      integ_vld <= '0;
      gfwd_vld  <= 1'b0;
      ifwd_vld  <= 1'b0;
    end else begin
      if (gain_we) begin
        gain_vld[s1_idx] <= 1'b1;
        gfwd_vld         <= 1'b1;
      end
      if (integ_we) begin
        integ_vld[s1_idx] <= 1'b1;
        ifwd_vld          <= 1'b1;
      end
    end
    if (gain_we) begin
      gfwd_idx  <= s1_idx;
      gfwd_data <= s1_gains;
    end
    if (integ_we) begin
      ifwd_idx  <= s1_idx;
      ifwd_data <= integ_wdata;
    end
  end

  // stage 2: hand samples to the arithmetic pipeline, drop loads and out-of-range joints
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (en2) begin
      stage_valid <= s1_valid && s1_present && (s1_op == OP_SAMPLE);
    end
    if (en2) begin
      stage.joint <= s1_joint;
      stage.perr  <= s1_perr;
      stage.vel   <= s1_vel;
      stage.ff    <= s1_ff;
      stage.gains <= gains_cur;
      stage.integ <= integ_new;
      stage.isat  <= integ_ovf;
    end
  end

endmodule

`default_nettype wire

// File: src/jpid_math.sv
// Arithmetic pipeline: gain products, partial sums, fraction shift and the
// saturating drive output register. Depends on jpid_pkg and jpid_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module jpid_math import jpid_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire jpid_stage_t stage,
  input  wire logic        stage_valid,
  output logic             stage_ready,
  jpid_rsp_if.source       rsp
);

  localparam int P_W    = GAIN_W + ERR_W;
  localparam int D_W    = GAIN_W + VAL_W;
  localparam int KL_W   = GAIN_W + INTEG_SPLIT + 1;
  localparam int KH_W   = GAIN_W + INTEG_W - INTEG_SPLIT;
  localparam int DIFF_W = SUM_W + 1;

  logic en_out, en3, en2, en1;

  logic                      m1_valid;
  logic signed [P_W-1:0]     m1_p;
  logic signed [D_W-1:0]     m1_d;
  logic signed [KL_W-1:0]    m1_kl;
  logic signed [KH_W-1:0]    m1_kh;
  logic signed [FF_W-1:0]    m1_ff;
  logic [JOINT_W-1:0]        m1_joint;
  logic                      m1_isat;

  logic                      m2_valid;
  logic signed [SUM_W-1:0]   m2_pd;
  logic signed [SUM_W-1:0]   m2_ki;
  logic signed [FF_W-1:0]    m2_ff;
  logic [JOINT_W-1:0]        m2_joint;
  logic                      m2_isat;

  logic                      m3_valid;
  logic signed [SUM_W-1:0]   m3_sum;
  logic signed [FF_W-1:0]    m3_ff;
  logic [JOINT_W-1:0]        m3_joint;
  logic                      m3_isat;

  logic signed [DIFF_W-1:0]  diff;
  logic                      drive_ovf;
  logic signed [DRIVE_W-1:0] drive_next;

  assign en_out      = !rsp.valid || rsp.ready;
  assign en3         = !m3_valid || en_out;
  assign en2         = !m2_valid || en3;
  assign en1         = !m1_valid || en2;
  assign stage_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      m3_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (en1)    m1_valid  <= stage_valid;
      if (en2)    m2_valid  <= m1_valid;
      if (en3)    m3_valid  <= m2_valid;
      if (en_out) rsp.valid <= m3_valid;
    end

    if (en1) begin
      m1_p     <= stage.gains.kp * stage.perr;
      m1_d     <= stage.gains.kd * stage.vel;
      m1_kl    <= stage.gains.ki * $signed({1'b0, stage.integ[INTEG_SPLIT-1:0]});
      m1_kh    <= stage.gains.ki * $signed(stage.integ[INTEG_W-1:INTEG_SPLIT]);
      m1_ff    <= stage.ff;
      m1_joint <= stage.joint;
      m1_isat  <= stage.isat;
    end

    if (en2) begin
      m2_pd    <= SUM_W'(m1_p) + SUM_W'(m1_d);
      m2_ki    <= SUM_W'(m1_kl) + (SUM_W'(m1_kh) <<< INTEG_SPLIT);
      m2_ff    <= m1_ff;
      m2_joint <= m1_joint;
      m2_isat  <= m1_isat;
    end

    if (en3) begin
      m3_sum   <= (m2_pd + m2_ki) >>> FRAC_BITS;
      m3_ff    <= m2_ff;
      m3_joint <= m2_joint;
      m3_isat  <= m2_isat;
    end

    if (en_out) begin
      rsp.joint_out <= m3_joint;
      rsp.drive     <= drive_next;
      rsp.saturated <= m3_isat || drive_ovf;
    end
  end

  always_comb begin
    diff      = DIFF_W'(m3_ff) - DIFF_W'(m3_sum);
    drive_ovf = diff[DIFF_W-1:DRIVE_W-1] != {(DIFF_W - DRIVE_W + 1){diff[DRIVE_W-1]}};
    if (drive_ovf) begin
      drive_next = diff[DIFF_W-1] ? DRIVE_MIN : DRIVE_MAX;
    end else begin
      drive_next = diff[DRIVE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sim/jpid_checker.sv
// Checker for the joint PID controller: watches the request and response
// channels, keeps its own gain tables and integrators, and scores each drive.
// Depends on jpid_pkg and the channel interfaces in jpid_if.
`timescale 1ns / 1ps

module jpid_checker import jpid_pkg::*; (
  input  logic clk,
  input  logic rst,
  jpid_req_if  req,
  jpid_rsp_if  rsp,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic [JOINT_W-1:0]        joint;
    logic signed [DRIVE_W-1:0] drive;
    logic                      sat;
  } drive_rec_t;

  logic signed [GAIN_W-1:0]  kp_tab  [NUM_JOINTS_DEF];
  logic signed [GAIN_W-1:0]  kd_tab  [NUM_JOINTS_DEF];
  logic signed [GAIN_W-1:0]  ki_tab  [NUM_JOINTS_DEF];
  logic signed [INTEG_W-1:0] err_sum [NUM_JOINTS_DEF];
  drive_rec_t                drive_q [$];
  int                        mismatches;

  function automatic drive_rec_t predict_drive(
    input logic [JOINT_W-1:0]      j,
    input logic signed [VAL_W-1:0] pos,
    input logic signed [VAL_W-1:0] vel,
    input logic signed [VAL_W-1:0] goal,
    input logic signed [FF_W-1:0]  ff
  );
    longint p, v, g, f, kp, kd, ki, perr, acc, sum, drv;
    drive_rec_t r;
    p  = pos;
    v  = vel;
    g  = goal;
    f  = ff;
    kp = kp_tab[j];
    kd = kd_tab[j];
    ki = ki_tab[j];
    acc = err_sum[j];
    r.sat = 1'b0;
    perr = p - g;
    acc  = acc + perr;
    if (acc > INTEG_MAX) begin
      acc = INTEG_MAX;
      r.sat = 1'b1;
    end else if (acc < INTEG_MIN) begin
      acc = INTEG_MIN;
      r.sat = 1'b1;
    end
    err_sum[j] = acc[INTEG_W-1:0];
    sum = kp * perr + kd * v + ki * acc;
    drv = f - (sum >>> FRAC_BITS_DEF);
    if (drv > DRIVE_MAX) begin
      drv = DRIVE_MAX;
      r.sat = 1'b1;
    end else if (drv < DRIVE_MIN) begin
      drv = DRIVE_MIN;
      r.sat = 1'b1;
    end
    r.joint = j;
    r.drive = drv[DRIVE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : score
    drive_rec_t want;
    if (rst) begin
      for (int i = 0; i < NUM_JOINTS_DEF; i++) begin
        kp_tab[i]  = '0;
        kd_tab[i]  = '0;
        ki_tab[i]  = '0;
        err_sum[i] = '0;
      end
      drive_q.delete();
      mismatches = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected drive: joint %0d drive %0d sat %0b", $realtime,
                     rsp.joint_out, rsp.drive, rsp.saturated);
        end else begin
          want = drive_q.pop_front();
          if (rsp.joint_out !== want.joint || rsp.drive !== want.drive ||
              rsp.saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: drive mismatch: got %0d/%0d/%0b, want %0d/%0d/%0b",
                       $realtime, rsp.joint_out, rsp.drive, rsp.saturated,
                       want.joint, want.drive, want.sat);
          end
        end
      end
      if (req.valid && req.ready && req.joint < NUM_JOINTS_DEF) begin
        if (req.opcode == OP_LOAD) begin
          kp_tab[req.joint]  = req.gain_p;
          kd_tab[req.joint]  = req.gain_d;
          ki_tab[req.joint]  = req.gain_i;
          err_sum[req.joint] = '0;
        end else begin
          drive_q.push_back(predict_drive(req.joint, req.position, req.velocity,
                                          req.pos_target, req.feedforward));
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= drive_q.size();
  end

endmodule

// File: sim/tb.sv
// Testbench top for the joint PID controller: clock, reset, bursty stimulus
// and a stalling response sink. Depends on jpid_pkg, jpid_if, jpid_checker
// and the controller RTL.
`timescale 1ns / 1ps

module tb import jpid_pkg::*; ;

  localparam logic signed [VAL_W-1:0] VAL_HI = VAL_W'(2 ** (VAL_W - 1) - 1);
  localparam logic signed [VAL_W-1:0] VAL_LO = VAL_W'(-(2 ** (VAL_W - 1)));

  typedef struct {
    jpid_op_t                  op;
    logic [JOINT_W-1:0]        joint;
    logic signed [VAL_W-1:0]   pos;
    logic signed [VAL_W-1:0]   vel;
    logic signed [VAL_W-1:0]   goal;
    logic signed [FF_W-1:0]    ff;
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  kd;
    logic signed [GAIN_W-1:0]  ki;
  } pid_item_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   burst_left;
  int   max_gap;
  bit   choke_pending;

  jpid_req_if req_ch ();
  jpid_rsp_if rsp_ch ();

  joint_pid_controller dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  jpid_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [VAL_W-1:0] rand_val();
    int r;
    r = 0;
    case ($urandom_range(0, 5))
      0: r = VAL_HI;
      1: r = VAL_LO;
      2: r = int'($urandom_range(0, 8192)) - 4096;
      3: r = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      default: r = int'($urandom);
    endcase
    return VAL_W'(r);
  endfunction

  function automatic logic signed [GAIN_W-1:0] rand_gain();
    int r;
    r = 0;
    case ($urandom_range(0, 7))
      0: r = VAL_HI;
      1: r = VAL_LO;
      2: r = int'($urandom);
      3, 4: r = int'($urandom_range(0, 512)) - 256;
      default: r = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return GAIN_W'(r);
  endfunction

  function automatic logic signed [FF_W-1:0] rand_ff();
    int r;
    r = 0;
    case ($urandom_range(0, 5))
      0: r = int'($urandom);
      1: r = DRIVE_MAX;
      2: r = DRIVE_MIN;
      default: r = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
    return r;
  endfunction

  function automatic pid_item_t mk_load(input logic [JOINT_W-1:0] j,
                                        input logic signed [GAIN_W-1:0] kp,
                                        input logic signed [GAIN_W-1:0] kd,
                                        input logic signed [GAIN_W-1:0] ki);
    pid_item_t it;
    it.op    = OP_LOAD;
    it.joint = j;
    it.pos   = VAL_W'($urandom);
    it.vel   = VAL_W'($urandom);
    it.goal  = VAL_W'($urandom);
    it.ff    = $urandom;
    it.kp    = kp;
    it.kd    = kd;
    it.ki    = ki;
    return it;
  endfunction

  function automatic pid_item_t mk_sample(input logic [JOINT_W-1:0] j,
                                          input logic signed [VAL_W-1:0] pos,
                                          input logic signed [VAL_W-1:0] vel,
                                          input logic signed [VAL_W-1:0] goal,
                                          input logic signed [FF_W-1:0] ff);
    pid_item_t it;
    it.op    = OP_SAMPLE;
    it.joint = j;
    it.pos   = pos;
    it.vel   = vel;
    it.goal  = goal;
    it.ff    = ff;
    it.kp    = GAIN_W'($urandom);
    it.kd    = GAIN_W'($urandom);
    it.ki    = GAIN_W'($urandom);
    return it;
  endfunction

  function automatic pid_item_t rand_item();
    logic [JOINT_W-1:0] j;
    j = ($urandom_range(0, 1) == 0) ? JOINT_W'($urandom_range(0, 3)) : JOINT_W'($urandom);
    if ($urandom_range(0, 7) == 0)
      return mk_load(j, rand_gain(), rand_gain(), rand_gain());
    return mk_sample(j, rand_val(), rand_val(), rand_val(), rand_ff());
  endfunction

  // offer one transaction at a falling edge; return at a falling edge after it is taken and any idle gap
  task automatic offer(input pid_item_t it);
    int gap;
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= it.op;
    req_ch.joint         <= it.joint;
    req_ch.position      <= it.pos;
    req_ch.velocity      <= it.vel;
    req_ch.pos_target    <= it.goal;
    req_ch.feedforward   <= it.ff;
    req_ch.gain_p        <= it.kp;
    req_ch.gain_d        <= it.kd;
    req_ch.gain_i        <= it.ki;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  initial begin : stimulus
    req_ch.valid         = 1'b0;
    req_ch.opcode        = OP_LOAD;
    req_ch.joint         = '0;
    req_ch.position      = '0;
    req_ch.velocity      = '0;
    req_ch.pos_target    = '0;
    req_ch.feedforward   = '0;
    req_ch.gain_p        = '0;
    req_ch.gain_d        = '0;
    req_ch.gain_i        = '0;
    rst           = 1'b1;
    burst_left    = 30;
    max_gap       = 6;
    choke_pending = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // gains still zero after reset: drive equals feedforward
    offer(mk_sample(0, VAL_HI, VAL_HI, VAL_LO, DRIVE_MAX));
    offer(mk_sample(0, VAL_LO, VAL_LO, VAL_HI, DRIVE_MIN));
    // extreme gains: drive clamps both ways
    offer(mk_load(1, VAL_HI, VAL_LO, -1));
    offer(mk_sample(1, VAL_HI, VAL_HI, VAL_LO, 0));
    offer(mk_sample(1, VAL_LO, VAL_LO, VAL_HI, DRIVE_MAX));
    offer(mk_sample(1, 0, 0, 0, 0));
    // unit gains: negative sum floors toward minus infinity
    offer(mk_load(15, 1, 1, 1));
    offer(mk_sample(15, -1, 0, 0, 0));
    offer(mk_sample(15, -1, 0, 0, 0));
    offer(mk_sample(15, 3, -5, 0, 7));
    offer(mk_sample(15, 100, 1, -100, -1));
    // reload clears the integrator
    offer(mk_load(1, 2, -3, 4));
    offer(mk_sample(1, 4096, -4096, 0, 0));
    offer(mk_sample(1, 4096, -4096, 0, 0));
    offer(mk_load(4, VAL_LO, VAL_LO, VAL_LO));
    offer(mk_sample(4, VAL_HI, VAL_LO, VAL_LO, DRIVE_MIN));
    offer(mk_sample(4, VAL_LO, VAL_HI, VAL_HI, DRIVE_MAX));
    offer(mk_sample(4, 0, -1, 0, -1));
    offer(mk_load(0, VAL_HI, VAL_HI, VAL_HI));
    offer(mk_sample(0, -1, -1, -1, DRIVE_MAX));

    // wind two integrators up, one each way
    max_gap = 2;
    offer(mk_load(2, 3, -2, 1));
    offer(mk_load(3, -1, 1, -1));
    for (int k = 0; k < 32; k++) begin
      offer(mk_sample(2, VAL_HI, rand_val(), VAL_LO,
                      int'($urandom_range(0, 1 << 28)) - (1 << 27)));
      offer(mk_sample(3, VAL_LO, rand_val(), VAL_HI,
                      int'($urandom_range(0, 1 << 28)) - (1 << 27)));
    end

    max_gap = 6;
    for (int k = 0; k < 320; k++) begin
      if (k == 150) begin
        choke_pending = 1'b1;
        burst_left    = 60;
      end
      offer(rand_item());
    end
    req_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : rx_pacing
    int hold, mode, seg, tick;
    hold = 0;
    mode = 0;
    seg  = 0;
    tick = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (choke_pending) begin
        choke_pending = 1'b0;
        hold = 80;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 3);
          seg  = $urandom_range(8, 64);
        end
        seg--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
          default: rsp_ch.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
